// ===== src/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, service codes and response tables for the diagnostic server.
// ----------------------------------------------------------------------------
package drs_pkg;

  typedef struct packed {
    logic [7:0] service_id;
    logic [7:0] req_len;
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [7:0] data_byte2;
    logic [7:0] data_byte3;
    logic [7:0] data_byte4;
  } req_t;

  typedef struct packed {
    logic       has_response;
    logic [7:0] resp_byte;
    logic       last_byte;
  } rsp_t;

  // Service identifiers
  localparam logic [7:0] SID_SESSION_CTRL = 8'h10;
  localparam logic [7:0] SID_ECU_RESET    = 8'h11;
  localparam logic [7:0] SID_READ_DID     = 8'h22;
  localparam logic [7:0] SID_SECURITY     = 8'h27;
  localparam logic [7:0] SID_TESTER_PRES  = 8'h3E;
  localparam logic [7:0] SID_POS_OFFSET   = 8'h40;
  localparam logic [7:0] SID_NEG_RESP     = 8'h7F;

  // Negative response codes
  localparam logic [7:0] NRC_SERVICE_NS   = 8'h11;
  localparam logic [7:0] NRC_SUBFUNC_NS   = 8'h12;
  localparam logic [7:0] NRC_BAD_LENGTH   = 8'h13;
  localparam logic [7:0] NRC_OUT_OF_RANGE = 8'h31;
  localparam logic [7:0] NRC_COND_NOT_OK  = 8'h33;
  localparam logic [7:0] NRC_INVALID_KEY  = 8'h35;
  localparam logic [7:0] NRC_EXCEED_TRIES = 8'h36;

  // Security access subfunctions
  localparam logic [7:0] SA_REQ_SEED = 8'h01;
  localparam logic [7:0] SA_SEND_KEY = 8'h02;

  // Data identifiers
  localparam logic [15:0] DID_VIN    = 16'hF190;
  localparam logic [15:0] DID_SERIAL = 16'hF18C;
  localparam logic [15:0] DID_SWVER  = 16'hF188;

  localparam logic [1:0]  SESSION_DEFAULT = 2'd1;
  localparam logic [31:0] SEED_CONST      = 32'h1234_5678;
  localparam logic [31:0] KEY_MASK        = 32'hA5A5_A5A5;
  localparam logic [7:0]  TRIES_LIMIT     = 8'd3;

  localparam int unsigned MaxRespLen = 20;
  localparam int unsigned IdxW       = $clog2(MaxRespLen);

  typedef enum logic [2:0] {
    K_NEG,
    K_SESSION,
    K_ECHO,
    K_SEED,
    K_VIN,
    K_SERIAL,
    K_SWVER
  } kind_e;

  // Classified request handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  sid;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [31:0] word;   // seed bytes, or the NRC in the low byte
  } desc_t;

  function automatic logic [IdxW-1:0] resp_len(kind_e kind);
    logic [IdxW-1:0] len;
    unique case (kind)
      K_NEG:     len = IdxW'(3);
      K_SESSION: len = IdxW'(6);
      K_ECHO:    len = IdxW'(2);
      K_SEED:    len = IdxW'(6);
      K_VIN:     len = IdxW'(20);
      K_SERIAL:  len = IdxW'(14);
      K_SWVER:   len = IdxW'(6);
      default:   len = IdxW'(3);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] vin_char(logic [IdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = "W";
      5'd1:    c = "V";
      5'd2:    c = "W";
      5'd3:    c = "Z";
      5'd4:    c = "Z";
      5'd5:    c = "Z";
      5'd6:    c = "1";
      5'd7:    c = "K";
      5'd8:    c = "Z";
      5'd9:    c = "1";
      5'd10:   c = "A";
      5'd11:   c = "2";
      5'd12:   c = "3";
      5'd13:   c = "4";
      5'd14:   c = "5";
      5'd15:   c = "6";
      5'd16:   c = "7";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] serial_char(logic [IdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = "S";
      5'd1:    c = "N";
      5'd2:    c = "1";
      5'd3:    c = "2";
      5'd4:    c = "3";
      5'd5:    c = "4";
      5'd6:    c = "5";
      5'd7:    c = "6";
      5'd8:    c = "7";
      5'd9:    c = "8";
      5'd10:   c = "9";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] swver_char(logic [IdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = 8'h01;
      5'd1:    c = 8'h00;
      5'd2:    c = 8'h05;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Byte number idx of the response described by desc
  function automatic logic [7:0] resp_at(desc_t desc, logic [IdxW-1:0] idx);
    logic [7:0]      b;
    logic [IdxW-1:0] t;
    t = idx - IdxW'(3);
    if (idx == '0) begin
      b = (desc.kind == K_NEG) ? SID_NEG_RESP : desc.sid + SID_POS_OFFSET;
    end else if (idx == IdxW'(1)) begin
      b = (desc.kind == K_NEG) ? desc.sid : desc.d0;
    end else begin
      unique case (desc.kind)
        K_NEG:     b = desc.word[7:0];
        K_SESSION: begin
          unique case (idx)
            5'd2:    b = 8'h00;
            5'd3:    b = 8'h32;
            5'd4:    b = 8'h01;
            default: b = 8'hF4;
          endcase
        end
        K_SEED: begin
          unique case (idx)
            5'd2:    b = desc.word[31:24];
            5'd3:    b = desc.word[23:16];
            5'd4:    b = desc.word[15:8];
            default: b = desc.word[7:0];
          endcase
        end
        K_VIN:    b = (idx == IdxW'(2)) ? desc.d1 : vin_char(t);
        K_SERIAL: b = (idx == IdxW'(2)) ? desc.d1 : serial_char(t);
        K_SWVER:  b = (idx == IdxW'(2)) ? desc.d1 : swver_char(t);
        default:  b = desc.d0;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== src/drs_front.sv =====
// ----------------------------------------------------------------------------
// drs_front
// Decodes one request, updates session and security state, and classifies
// the response into a descriptor for the back end.
// ----------------------------------------------------------------------------
module drs_front import drs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  req_t  req_i,
  output desc_t desc_o
);

  logic [1:0]  session_q, session_d;
  logic        unlocked_q, unlocked_d;
  logic [31:0] seed_q, seed_d;
  logic [7:0]  fails_q, fails_d;

  logic [7:0]  fails_inc;
  logic [31:0] key;
  logic        d0_range_ok;

  assign fails_inc   = (fails_q == 8'hFF) ? fails_q : fails_q + 8'd1;
  assign key         = {req_i.data_byte1, req_i.data_byte2, req_i.data_byte3,
                        req_i.data_byte4};
  assign d0_range_ok = (req_i.data_byte0 >= 8'd1) && (req_i.data_byte0 <= 8'd3);

  always_comb begin
    session_d   = session_q;
    unlocked_d  = unlocked_q;
    seed_d      = seed_q;
    fails_d     = fails_q;
    desc_o.kind = K_NEG;
    desc_o.sid  = req_i.service_id;
    desc_o.d0   = req_i.data_byte0;
    desc_o.d1   = req_i.data_byte1;
    desc_o.word = {24'h0, NRC_SERVICE_NS};

    unique case (req_i.service_id)
      SID_SESSION_CTRL: begin
        priority if (req_i.req_len < 8'd1) begin
          desc_o.word[7:0] = NRC_BAD_LENGTH;
        end else if (!d0_range_ok) begin
          desc_o.word[7:0] = NRC_SUBFUNC_NS;
        end else begin
          session_d   = req_i.data_byte0[1:0];
          desc_o.kind = K_SESSION;
        end
      end
      SID_ECU_RESET: begin
        priority if (req_i.req_len < 8'd1) begin
          desc_o.word[7:0] = NRC_BAD_LENGTH;
        end else if (!d0_range_ok) begin
          desc_o.word[7:0] = NRC_SUBFUNC_NS;
        end else if (!unlocked_q && session_q != SESSION_DEFAULT) begin
          desc_o.word[7:0] = NRC_COND_NOT_OK;
        end else begin
          desc_o.kind = K_ECHO;
        end
      end
      SID_SECURITY: begin
        priority if (req_i.req_len < 8'd1) begin
          desc_o.word[7:0] = NRC_BAD_LENGTH;
        end else if (req_i.data_byte0 == SA_REQ_SEED) begin
          desc_o.kind = K_SEED;
          if (unlocked_q) begin
            desc_o.word = '0;
          end else begin
            seed_d      = SEED_CONST;
            desc_o.word = SEED_CONST;
          end
        end else if (req_i.data_byte0 == SA_SEND_KEY) begin
          priority if (req_i.req_len < 8'd5) begin
            desc_o.word[7:0] = NRC_BAD_LENGTH;
          end else if (key == (seed_q ^ KEY_MASK)) begin
            unlocked_d  = 1'b1;
            fails_d     = '0;
            desc_o.kind = K_ECHO;
          end else begin
            fails_d          = fails_inc;
            desc_o.word[7:0] = (fails_inc >= TRIES_LIMIT) ? NRC_EXCEED_TRIES
                                                          : NRC_INVALID_KEY;
          end
        end else begin
          desc_o.word[7:0] = NRC_SUBFUNC_NS;
        end
      end
      SID_TESTER_PRES: begin
        if (req_i.req_len < 8'd1) begin
          desc_o.word[7:0] = NRC_BAD_LENGTH;
        end else begin
          desc_o.kind = K_ECHO;
        end
      end
      SID_READ_DID: begin
        priority if (req_i.req_len < 8'd2) begin
          desc_o.word[7:0] = NRC_BAD_LENGTH;
        end else if ({req_i.data_byte0, req_i.data_byte1} == DID_VIN) begin
          desc_o.kind = K_VIN;
        end else if ({req_i.data_byte0, req_i.data_byte1} == DID_SERIAL) begin
          desc_o.kind = K_SERIAL;
        end else if ({req_i.data_byte0, req_i.data_byte1} == DID_SWVER) begin
          desc_o.kind = K_SWVER;
        end else begin
          desc_o.word[7:0] = NRC_OUT_OF_RANGE;
        end
      end
      default: begin
        desc_o.word[7:0] = NRC_SERVICE_NS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q  <= SESSION_DEFAULT;
      unlocked_q <= 1'b0;
      seed_q     <= '0;
      fails_q    <= '0;
    end else if (accept_i) begin
      session_q  <= session_d;
      unlocked_q <= unlocked_d;
      seed_q     <= seed_d;
      fails_q    <= fails_d;
    end
  end

endmodule

// ===== src/drs_queue.sv =====
// ----------------------------------------------------------------------------
// drs_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module drs_queue import drs_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t data_i,
  input  logic  pop_i,
  output desc_t data_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== src/drs_back.sv =====
// ----------------------------------------------------------------------------
// drs_back
// Serializes the queued response into the output register one byte a cycle
// while not stalled, or one no-response item when the response exceeds the capacity.
// ----------------------------------------------------------------------------
module drs_back import drs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] cap_i,
  input  desc_t      desc_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_rsp_o
);

  logic            out_valid_q;
  rsp_t            out_rsp_q;
  logic [IdxW-1:0] idx_q;

  logic [IdxW-1:0] len;
  logic            fits;
  logic            load;
  logic            last;

  assign len   = resp_len(desc_i.kind);
  assign fits  = ({{(8 - IdxW){1'b0}}, len} <= cap_i);
  assign load  = !out_valid_q || !out_stall_i;
  assign last  = !fits || (idx_q == len - IdxW'(1));
  assign pop_o = load && !empty_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (!empty_i) begin
        idx_q <= last ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      out_rsp_q.has_response <= fits;
      out_rsp_q.resp_byte    <= fits ? resp_at(desc_i, idx_q) : 8'h00;
      out_rsp_q.last_byte    <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_noresp_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_rsp_q.has_response |->
      out_rsp_q.last_byte && out_rsp_q.resp_byte == 8'h00)
    else $error("no-response item must be a single zero last item");

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < len)
    else $error("byte index beyond response length");

  a_idx_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0)
    else $error("byte index not cleared after last byte");

  a_idle_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == '0)
    else $error("byte index left nonzero with queue empty");

endmodule

// ===== src/diagnostic_request_server.sv =====
// ----------------------------------------------------------------------------
// diagnostic_request_server
// Diagnostic request server: decodes requests, tracks session and security
// state, and streams positive or negative responses one byte per item.
// ----------------------------------------------------------------------------
// A taken request is written to the request queue, then its first response
//   byte is loaded into the output register. Throughput: one response byte
//   per cycle while the output is not stalled; a request yields 2 to 20
//   response bytes, or one no-response item when it does not fit the capacity.
// Requests are taken every cycle while the request queue has room.
// Reset: capacity 255, default session, locked, seed and failed count zero.
// ----------------------------------------------------------------------------
module diagnostic_request_server import drs_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] cap_q;
  logic       accept;
  logic       q_full, q_empty, q_pop;
  desc_t      front_desc, q_desc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 8'hFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  drs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .desc_o   (front_desc)
  );

  drs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_desc),
    .pop_i   (q_pop),
    .data_o  (q_desc),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  drs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .desc_i      (q_desc),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
